// ===== hw/rtl/cpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles that join the controller and the datapath of the conductivity meter.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Field and register widths
	localparam int ADC_BITS  = 12;
	localparam int SINE_W    = 11;
	localparam int CC_W      = 16;
	localparam int COEF_W    = 16;
	localparam int TEMP_W    = 16;
	localparam int AVG_W     = 16;
	localparam int COND_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Quotient bits of the divider: the top bit flags an overflow
	localparam int QUO_W = COND_W + 1;

	// Fraction bits added to the conductivity numerator
	localparam int COND_SHIFT = 22;

	// Compensation denominator: signed, wide enough for 1.0 + alpha*(t - 25)
	localparam int DENT_W = 35;
	// Positive denominator magnitude never exceeds 31 bits
	localparam int DENT_MAG_W = 31;

	localparam logic [TEMP_W:0]   TEMP_25_Q8 = 17'd6400;
	localparam logic [DENT_W-1:0] ONE_Q24    = 35'd16777216;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SINE_AMPLITUDE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_CONSTANT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFICIENT = 2'd2;

	// Register reset values
	localparam logic [SINE_W-1:0] SINE_RESET = 11'd1000;
	localparam logic [CC_W-1:0]   CC_RESET   = 16'd4096;
	localparam logic [COEF_W-1:0] COEF_RESET = 16'd1311;

	// Startup waves that refill the whole window
	localparam logic [1:0] PRIME_RESET = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic sample_acc;    // an item was accepted this cycle
		logic wave_start;    // wave just ended, prepare refill index
		logic fill_wr;       // write one window entry of a refill
		logic push;          // replace the oldest window entry
		logic mul1;          // first multiply stage
		logic mul2;          // form the compensation denominator and average
		logic mul3;          // full divisor and error flag
		logic div_start;     // launch the conductivity divider
		logic cond_load;     // capture the conductivity quotient
		logic cond_clear;    // zero conductivity on a compensation error
		logic out_load;      // copy the result into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fill;          // this wave refills the whole window
		logic fill_last;     // refill index at the final entry
		logic div_done;      // divider quotient is ready
		logic err;           // compensation denominator not positive or sine amplitude zero
	} status_t;

endpackage

// ===== hw/rtl/cpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_div
// Restoring divider, one quotient bit per cycle. Produces QUO_W quotient bits
// of num / den; the top bit set means the true quotient is at least
// 2^(QUO_W-1) and the lower bits are then meaningless.
// ----------------------------------------------------------------------------
module cpa_div #(
	parameter int NUM_W = 57,
	parameter int DEN_W = 49
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic [cpa_pkg::QUO_W-1:0]  quo
);
	import cpa_pkg::*;

	localparam int DSH_W = DEN_W + QUO_W - 1;
	localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int CNT_W = $clog2(QUO_W);

	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [CMP_W-1:0] rem_x;
	logic [CMP_W-1:0] dsh_x;
	logic [CMP_W-1:0] rem_sub;
	logic             ge;

	// Trial subtract of the shifted divisor
	always_comb begin
		rem_x   = CMP_W'(rem_q);
		dsh_x   = CMP_W'(dsh_q);
		ge      = (rem_x >= dsh_x);
		rem_sub = rem_x - dsh_x;
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, divisor and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, (QUO_W - 1)'(0)};
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_sub[NUM_W-1:0];
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hw/rtl/cpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer for the meter: takes samples, and at each wave end walks the
// window update, the multiply stages, the divider run if no error and the output load.
// ----------------------------------------------------------------------------
module cpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last_of_wave,
	output logic              out_valid,
	input  logic              out_ready,
	output cpa_pkg::cmd_t     cmd,
	input  cpa_pkg::status_t  status
);
	import cpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WAVE,
		S_FILL,
		S_PUSH,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_DIVC_GO,
		S_DIVC_RUN,
		S_LOAD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.sample_acc = 1'b1;
					if (last_of_wave) begin
						state_d = S_WAVE;
					end
				end
			end
			S_WAVE: begin
				cmd.wave_start = 1'b1;
				state_d = status.fill ? S_FILL : S_PUSH;
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (status.fill_last) begin
					state_d = S_MUL1;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = S_DIVC_GO;
			end
			S_DIVC_GO: begin
				if (status.err) begin
					cmd.cond_clear = 1'b1;
					state_d        = S_LOAD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVC_RUN;
				end
			end
			S_DIVC_RUN: begin
				if (status.div_done) begin
					cmd.cond_load = 1'b1;
					state_d       = S_LOAD;
				end
			end
			S_LOAD: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/cpa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_dp
// Datapath: configuration registers, peak tracking, the moving-average
// window memory and sum, the compensation multipliers, the divider
// and the output payload register.
// ----------------------------------------------------------------------------
module cpa_dp #(
	parameter int FILTER_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cpa_pkg::cmd_t                     cmd,
	output cpa_pkg::status_t                  status,
	input  logic [cpa_pkg::ADC_BITS-1:0]      sample,
	input  logic                              last_of_wave,
	input  logic signed [cpa_pkg::TEMP_W-1:0] temperature,
	input  logic                              reprime,
	input  logic                              cfg_we,
	input  logic [cpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpa_pkg::CFG_DAT_W-1:0]     cfg_data,
	output logic [cpa_pkg::ADC_BITS-1:0]      peak_to_peak,
	output logic [cpa_pkg::AVG_W-1:0]         average_q4,
	output logic [cpa_pkg::COND_W-1:0]        conductivity,
	output logic                              saturated,
	output logic                              compensation_error
);
	import cpa_pkg::*;

	localparam int PTR_W  = $clog2(FILTER_DEPTH);
	localparam int SUM_W  = ADC_BITS + $clog2(FILTER_DEPTH);
	localparam int DSA_W  = $clog2(FILTER_DEPTH + 1) + SINE_W;
	localparam int DEN_W  = DSA_W + DENT_MAG_W;
	localparam int PROD_W = SUM_W + CC_W;
	localparam int NUM_W  = PROD_W + COND_SHIFT + 1;
	localparam logic [ADC_BITS-1:0] ADC_FULL = '1;

	// Average by reciprocal multiply: dividend width, shift and multiplier width
	localparam int AVG_N_W = SUM_W + 5;
	localparam int AVG_K   = AVG_N_W + $clog2(FILTER_DEPTH);
	localparam int AVG_M_W = AVG_N_W + 2;
	localparam int AVG_P_W = AVG_N_W + AVG_M_W;
	// Rounded-up reciprocal of the depth, exact for any dividend below 2^AVG_N_W
	localparam logic [AVG_M_W-1:0] AVG_RECIP =
		AVG_M_W'(((64'd1 << AVG_K) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));

	// Configuration
	logic [SINE_W-1:0] sine_q;
	logic [CC_W-1:0]   cc_q;
	logic [COEF_W-1:0] coef_q;

	// Wave tracking and window control
	logic [ADC_BITS-1:0] max_q;
	logic [ADC_BITS-1:0] min_q;
	logic [ADC_BITS-1:0] amp_q;
	logic [TEMP_W-1:0]   temp_q;
	logic [1:0]          prime_q;
	logic                fill_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    fill_idx_q;
	logic [SUM_W-1:0]    sum_q;

	// Window memory
	logic [ADC_BITS-1:0] win_mem [FILTER_DEPTH];
	logic [ADC_BITS-1:0] rd_q;
	logic                mem_we;
	logic [PTR_W-1:0]    mem_waddr;

	// Arithmetic
	logic [PROD_W-1:0]        num_prod_q;
	logic signed [33:0]       tprod_q;
	logic [DSA_W-1:0]         dsa_q;
	logic [DENT_W-1:0]        dent_q;
	logic [DEN_W-1:0]         den_c_q;
	logic                     err_q;
	logic signed [TEMP_W:0]   tdiff;
	logic [ADC_BITS-1:0]      max_n;
	logic [ADC_BITS-1:0]      min_n;
	logic [1:0]               prime_n;
	logic [AVG_N_W-1:0]       avg_num;
	logic [AVG_P_W-1:0]       avg_prod_q;

	// Divider hookup
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	// Results
	logic [AVG_W-1:0]    avg_q;
	logic [COND_W-1:0]   cond_q;
	logic                sat_q;
	logic [ADC_BITS-1:0] out_ptp_q;
	logic [AVG_W-1:0]    out_avg_q;
	logic [COND_W-1:0]   out_cond_q;
	logic                out_sat_q;
	logic                out_err_q;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_q <= SINE_RESET;
			cc_q   <= CC_RESET;
			coef_q <= COEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SINE_AMPLITUDE:   sine_q <= cfg_data[SINE_W-1:0];
				REG_CELL_CONSTANT:    cc_q   <= cfg_data[CC_W-1:0];
				REG_TEMP_COEFFICIENT: coef_q <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Extremes including the current sample; reprime raises the count to one
	always_comb begin
		max_n   = (sample > max_q) ? sample : max_q;
		min_n   = (sample < min_q) ? sample : min_q;
		prime_n = (reprime && (prime_q == 2'd0)) ? 2'd1 : prime_q;
	end

	// Peak tracking, prime count and window pointer/sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= '0;
			min_q      <= ADC_FULL;
			prime_q    <= PRIME_RESET;
			fill_q     <= 1'b0;
			wp_q       <= '0;
			fill_idx_q <= '0;
			sum_q      <= '0;
		end else begin
			if (cmd.sample_acc) begin
				if (last_of_wave && (prime_n != 2'd0)) begin
					prime_q <= prime_n - 2'd1;
				end else begin
					prime_q <= prime_n;
				end
				if (last_of_wave) begin
					max_q  <= '0;
					min_q  <= ADC_FULL;
					fill_q <= (prime_n != 2'd0);
				end else begin
					max_q <= max_n;
					min_q <= min_n;
				end
			end
			if (cmd.wave_start) begin
				fill_idx_q <= '0;
			end
			if (cmd.fill_wr) begin
				fill_idx_q <= fill_idx_q + 1'b1;
				sum_q      <= SUM_W'(amp_q) * SUM_W'(FILTER_DEPTH);
			end
			if (cmd.push) begin
				sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(amp_q);
				if (wp_q == PTR_W'(FILTER_DEPTH - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	// Latch amplitude and temperature at wave end
	always_ff @(posedge clk) begin
		if (cmd.sample_acc && last_of_wave) begin
			amp_q  <= (max_n >= min_n) ? (max_n - min_n) : '0;
			temp_q <= temperature;
		end
	end

	// Window memory: one write port, registered read at the write pointer
	assign mem_we    = cmd.fill_wr || cmd.push;
	assign mem_waddr = cmd.fill_wr ? fill_idx_q : wp_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_waddr] <= amp_q;
		end
		rd_q <= win_mem[wp_q];
	end

	// Multiply stages for numerator, average and compensated divisor
	assign tdiff   = $signed({temp_q[TEMP_W-1], temp_q}) - $signed(TEMP_25_Q8);
	assign avg_num = AVG_N_W'({sum_q, 4'b0}) + AVG_N_W'(FILTER_DEPTH / 2);

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			num_prod_q <= PROD_W'(sum_q) * PROD_W'(cc_q);
			tprod_q    <= $signed({1'b0, coef_q}) * tdiff;
			dsa_q      <= DSA_W'(FILTER_DEPTH) * DSA_W'(sine_q);
			avg_prod_q <= AVG_P_W'(avg_num) * AVG_P_W'(AVG_RECIP);
		end
		if (cmd.mul2) begin
			dent_q <= {tprod_q[33], tprod_q} + ONE_Q24;
		end
		if (cmd.mul3) begin
			den_c_q <= DEN_W'(dsa_q) * DEN_W'(dent_q[DENT_MAG_W-1:0]);
			err_q   <= dent_q[DENT_W-1] || (dent_q == '0) || (dsa_q == '0);
		end
	end

	// Divider operands: rounded conductivity
	assign div_num = NUM_W'({num_prod_q, COND_SHIFT'(0)}) + NUM_W'(den_c_q >> 1);
	assign div_den = den_c_q;

	cpa_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Capture the average and conductivity; clip conductivity on overflow, zero it on an error
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			avg_q <= avg_prod_q[AVG_K +: AVG_W];
		end
		if (cmd.cond_load) begin
			sat_q  <= div_quo[QUO_W-1];
			cond_q <= div_quo[QUO_W-1] ? '1 : div_quo[COND_W-1:0];
		end
		if (cmd.cond_clear) begin
			sat_q  <= 1'b0;
			cond_q <= '0;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ptp_q  <= amp_q;
			out_avg_q  <= avg_q;
			out_cond_q <= cond_q;
			out_sat_q  <= sat_q;
			out_err_q  <= err_q;
		end
	end

	always_comb begin
		status.fill      = fill_q;
		status.fill_last = (fill_idx_q == PTR_W'(FILTER_DEPTH - 1));
		status.div_done  = div_done;
		status.err       = err_q;
	end

	assign peak_to_peak       = out_ptp_q;
	assign average_q4         = out_avg_q;
	assign conductivity       = out_cond_q;
	assign saturated          = out_sat_q;
	assign compensation_error = out_err_q;

endmodule

// ===== hw/rtl/conductivity_peak_average_top.sv =====
`timescale 1ns / 1ps
// A sample without the wave-end mark is taken while idle. A wave-end sample raises
// out_valid after the window update (a refill writes every entry), the multiply
// stages and the 25-step divider, which a compensation error skips.
// Throughput: one sample per cycle inside a wave; after a wave end the input
// stalls until the result is in the output register, longer while it is held.
// Reset: asynchronous; control and config registers reset to defaults; window is refilled.
// ----------------------------------------------------------------------------
// conductivity_peak_average_top
// Peak-to-peak conductivity meter with a moving-average window and
// temperature compensation.
// ----------------------------------------------------------------------------
module conductivity_peak_average_top #(
	parameter int FILTER_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cpa_pkg::ADC_BITS-1:0]      sample,
	input  logic                              last_of_wave,
	input  logic signed [cpa_pkg::TEMP_W-1:0] temperature,
	input  logic                              reprime,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cpa_pkg::ADC_BITS-1:0]      peak_to_peak,
	output logic [cpa_pkg::AVG_W-1:0]         average_q4,
	output logic [cpa_pkg::COND_W-1:0]        conductivity,
	output logic                              saturated,
	output logic                              compensation_error,
	input  logic                              cfg_we,
	input  logic [cpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpa_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import cpa_pkg::*;

	cmd_t    cmd;
	status_t status;

	cpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.last_of_wave(last_of_wave),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.status      (status)
	);

	cpa_dp #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.sample            (sample),
		.last_of_wave      (last_of_wave),
		.temperature       (temperature),
		.reprime           (reprime),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.peak_to_peak      (peak_to_peak),
		.average_q4        (average_q4),
		.conductivity      (conductivity),
		.saturated         (saturated),
		.compensation_error(compensation_error)
	);

endmodule
